// ----- rtl/h264rw_pkg.sv -----
// shared types, constants and the level limits table for the reorder window block
`default_nettype none

package h264rw_pkg;

   localparam logic [7:0] DPB_CAP = 8'd16;

   localparam int MB_LOG2 = 4;
   localparam int PIC_W   = 15;
   localparam int MBQ_W   = PIC_W - MB_LOG2;
   localparam int CNT_W   = 2 * MBQ_W;
   localparam int MBS_W   = 20;
   localparam int QUO_W   = 9;
   localparam int DSH_W   = CNT_W + QUO_W - 1;
   localparam int NUM_DIV_CELLS = QUO_W;

   localparam logic [7:0] LEVEL_1B = 8'd9;
   localparam logic [7:0] LEVEL_11 = 8'd11;

   localparam logic [7:0] PROFILE_BASELINE    = 8'd66;
   localparam logic [7:0] PROFILE_MAIN        = 8'd77;
   localparam logic [7:0] PROFILE_SCALABLE_BL = 8'd83;
   localparam logic [7:0] PROFILE_CAVLC444    = 8'd44;
   localparam logic [7:0] PROFILE_SCALABLE_HI = 8'd86;
   localparam logic [7:0] PROFILE_HIGH        = 8'd100;
   localparam logic [7:0] PROFILE_HIGH10      = 8'd110;
   localparam logic [7:0] PROFILE_HIGH422     = 8'd122;
   localparam logic [7:0] PROFILE_HIGH444     = 8'd244;

   typedef struct packed {
      logic [7:0]       level_code;
      logic [7:0]       profile_code;
      logic             constraint_three;
      logic             vui_present;
      logic             restriction_present;
      logic [7:0]       dec_frame_buffering;
      logic [7:0]       reorder_frames_in;
      logic [PIC_W-1:0] pic_width;
      logic [PIC_W-1:0] pic_height;
   } req_word_type;

   typedef struct packed {
      logic [7:0] dpb_frames;
      logic [7:0] reorder_window;
      logic       level_found;
   } rsp_word_type;

   typedef struct packed {
      logic [MBS_W-1:0] rem;
      logic [DSH_W-1:0] dshift;
      logic [QUO_W-1:0] quo;
      logic             restricted;
      logic             use_cap;
      logic             zero_reorder;
      logic             found;
      logic [7:0]       dec_buf;
      logic [7:0]       reorder_in;
   } stage_type;

   typedef struct packed {
      logic             found;
      logic [MBS_W-1:0] mbs;
   } level_limit_type;

   function automatic level_limit_type lookup_level(input logic [7:0] level);
      level_limit_type res;
      res.found = 1'b1;
      unique case (level)
         8'd9:    res.mbs = MBS_W'(396);
         8'd10:   res.mbs = MBS_W'(396);
         8'd11:   res.mbs = MBS_W'(900);
         8'd12:   res.mbs = MBS_W'(2376);
         8'd13:   res.mbs = MBS_W'(2376);
         8'd20:   res.mbs = MBS_W'(2376);
         8'd21:   res.mbs = MBS_W'(4752);
         8'd22:   res.mbs = MBS_W'(8100);
         8'd30:   res.mbs = MBS_W'(8100);
         8'd31:   res.mbs = MBS_W'(18000);
         8'd32:   res.mbs = MBS_W'(20480);
         8'd40:   res.mbs = MBS_W'(32768);
         8'd41:   res.mbs = MBS_W'(32768);
         8'd42:   res.mbs = MBS_W'(34816);
         8'd50:   res.mbs = MBS_W'(110400);
         8'd51:   res.mbs = MBS_W'(184320);
         8'd52:   res.mbs = MBS_W'(184320);
         8'd60:   res.mbs = MBS_W'(696320);
         8'd61:   res.mbs = MBS_W'(696320);
         8'd62:   res.mbs = MBS_W'(696320);
         default: begin
            res.found = 1'b0;
            res.mbs   = '0;
         end
      endcase
      return res;
   endfunction

   function automatic logic intra_only_profile(input logic [7:0] profile);
      logic res;
      case (profile) inside
         PROFILE_CAVLC444, PROFILE_SCALABLE_HI, PROFILE_HIGH,
         PROFILE_HIGH10, PROFILE_HIGH422, PROFILE_HIGH444: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/h264rw_if.sv -----
// valid/ready channel interfaces for the parameter set and result words
`default_nettype none

interface h264rw_req_if
   import h264rw_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface h264rw_rsp_if
   import h264rw_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/h264rw_front.sv -----
// head cell: level remap, limits lookup, macroblock count and divisor setup
`default_nettype none

module h264rw_front
   import h264rw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_word_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output stage_type         out_data
);

   logic            valid_ff;
   logic            valid_in;
   stage_type       data_ff;
   stage_type       data_in;
   logic [7:0]      level;
   level_limit_type limit;
   logic [MBQ_W-1:0] w_mbs;
   logic [MBQ_W-1:0] h_mbs;
   logic [CNT_W-1:0] count;
   logic            is_baseline_main;

   always_comb begin
      is_baseline_main = (in_data.profile_code == PROFILE_BASELINE) ||
                         (in_data.profile_code == PROFILE_MAIN);
      level = in_data.level_code;
      if ((in_data.level_code == LEVEL_11) && is_baseline_main && in_data.constraint_three) begin
         level = LEVEL_1B;
      end
      limit = lookup_level(level);
      w_mbs = in_data.pic_width[PIC_W-1:MB_LOG2];
      h_mbs = in_data.pic_height[PIC_W-1:MB_LOG2];
      count = CNT_W'(w_mbs) * CNT_W'(h_mbs);

      data_in.rem          = limit.mbs;
      data_in.dshift       = {count, {(QUO_W-1){1'b0}}};
      data_in.quo          = '0;
      data_in.restricted   = in_data.vui_present & in_data.restriction_present;
      data_in.use_cap      = !limit.found || (count == '0);
      data_in.zero_reorder = (in_data.profile_code == PROFILE_BASELINE) ||
                             (in_data.profile_code == PROFILE_SCALABLE_BL) ||
                             (in_data.constraint_three &&
                              intra_only_profile(in_data.profile_code));
      data_in.found        = limit.found;
      data_in.dec_buf      = in_data.dec_frame_buffering;
      data_in.reorder_in   = in_data.reorder_frames_in;

      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/h264rw_div_cell.sv -----
// one restoring division cell: compare, subtract, shift divisor down
`default_nettype none

module h264rw_div_cell
   import h264rw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire stage_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output stage_type      out_data
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   logic      fits;

   always_comb begin
      fits    = DSH_W'(in_data.rem) >= in_data.dshift;
      data_in = in_data;
      if (fits) begin
         data_in.rem = in_data.rem - in_data.dshift[MBS_W-1:0];
      end
      data_in.dshift = in_data.dshift >> 1;
      data_in.quo    = {in_data.quo[QUO_W-2:0], fits};

      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/h264rw_back.sv -----
// tail cell: buffer size clamp, reorder window select and output register
`default_nettype none

module h264rw_back
   import h264rw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire stage_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output rsp_word_type   out_data
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type data_ff;
   rsp_word_type data_in;
   logic [7:0]   dpb;
   logic [7:0]   reorder;

   always_comb begin
      if (in_data.restricted) begin
         dpb = (in_data.dec_buf == '0) ? 8'd1 : in_data.dec_buf;
      end else if (in_data.use_cap) begin
         dpb = DPB_CAP;
      end else if (in_data.quo[QUO_W-1] || (in_data.quo[QUO_W-2:0] > DPB_CAP)) begin
         dpb = DPB_CAP;
      end else begin
         dpb = in_data.quo[QUO_W-2:0];
      end

      if (in_data.restricted) begin
         reorder = (in_data.reorder_in > dpb) ? dpb : in_data.reorder_in;
      end else if (in_data.zero_reorder) begin
         reorder = '0;
      end else begin
         reorder = dpb;
      end

      data_in.dpb_frames     = dpb;
      data_in.reorder_window = reorder;
      data_in.level_found    = in_data.found;

      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/h264_reorder_window_calc.sv -----
// top level: dpb size and reorder window from sequence parameter set fields
//
// channel   dir   word                      handshake
// req_bus   in    sps fields (req_word)     valid/ready
// rsp_bus   out   dpb, reorder, found       valid/ready
//
// one word per cycle while rsp_bus is ready; eleven register stages (front cell, nine divide cells, output cell)
// result word registered in turn by the front cell, the divide cells and the output cell
// the dpb divide is done by the nine restoring subtract cells
// synchronous reset clears the valid bit of every cell
// each cell holds its word while the next one is full and stalled

`default_nettype none

module h264_reorder_window_calc
   import h264rw_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   h264rw_req_if.sink  req_bus,
   h264rw_rsp_if.source rsp_bus
);

   logic      cell_valid [0:NUM_DIV_CELLS];
   logic      cell_ready [0:NUM_DIV_CELLS];
   stage_type cell_data  [0:NUM_DIV_CELLS];

   h264rw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_bus.data),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_data  (cell_data[0])
   );

   for (genvar i = 0; i < NUM_DIV_CELLS; i++) begin : g_div
      h264rw_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_ready (cell_ready[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   h264rw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cell_valid[NUM_DIV_CELLS]),
      .in_ready  (cell_ready[NUM_DIV_CELLS]),
      .in_data   (cell_data[NUM_DIV_CELLS]),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_bus.data)
   );

endmodule

`default_nettype wire

// ----- dv/h264_reorder_window_calc_tb.sv -----
// testbench for the dpb size and reorder window block: directed rows, then random sps words
`timescale 1ns / 100ps

module h264_reorder_window_calc_tb
   import h264rw_pkg::*;
();

   localparam int NUM_LEVELS       = 20;
   localparam int NUM_PROFILES     = 9;
   localparam int RANDOM_PER_PHASE = 535;
   localparam int NUM_PHASES       = 3;
   localparam int SETTLE_CYCLES    = 24;
   localparam int HOLD_CYCLES      = 150;
   localparam int HOLD_AT_RESULT   = 300;
   localparam int CYCLE_LIMIT      = 200000;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   h264rw_req_if req_bus ();
   h264rw_rsp_if rsp_bus ();

   h264_reorder_window_calc dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   logic [7:0] level_ids [NUM_LEVELS] = '{
      8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd20, 8'd21, 8'd22, 8'd30, 8'd31,
      8'd32, 8'd40, 8'd41, 8'd42, 8'd50, 8'd51, 8'd52, 8'd60, 8'd61, 8'd62
   };
   int unsigned level_mbs [NUM_LEVELS] = '{
      396, 396, 900, 2376, 2376, 2376, 4752, 8100, 8100, 18000,
      20480, 32768, 32768, 34816, 110400, 184320, 184320, 696320, 696320, 696320
   };
   logic [7:0] profile_ids [NUM_PROFILES] = '{
      PROFILE_BASELINE, PROFILE_MAIN, PROFILE_SCALABLE_BL, PROFILE_CAVLC444,
      PROFILE_SCALABLE_HI, PROFILE_HIGH, PROFILE_HIGH10, PROFILE_HIGH422,
      PROFILE_HIGH444
   };

   rsp_word_type expected_results [$];
   stim_row_type directed_rows [$];
   int unsigned  error_count   = 0;
   int unsigned  results_seen  = 0;
   int unsigned  cycle_count   = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  rcv_idle_pct  = 0;
   int unsigned  phase_send_idle [NUM_PHASES] = '{6, 77, 0};
   int unsigned  phase_rcv_idle  [NUM_PHASES] = '{77, 6, 0};

   function automatic rsp_word_type derive_dpb_window(input req_word_type w);
      logic [7:0]   lvl;
      bit           restricted;
      bit           found;
      int unsigned  mbs;
      int unsigned  wq;
      int unsigned  hq;
      int unsigned  count;
      int unsigned  dpb;
      int unsigned  reorder;
      rsp_word_type r;
      lvl = w.level_code;
      if (lvl == LEVEL_11 && w.constraint_three &&
          (w.profile_code == PROFILE_BASELINE || w.profile_code == PROFILE_MAIN)) begin
         lvl = LEVEL_1B;
      end
      found = 1'b0;
      mbs   = 0;
      foreach (level_ids[i]) begin
         if (level_ids[i] == lvl) begin
            found = 1'b1;
            mbs   = level_mbs[i];
         end
      end
      restricted = w.vui_present && w.restriction_present;
      if (restricted) begin
         dpb = (w.dec_frame_buffering == 8'd0) ? 1 : w.dec_frame_buffering;
      end else if (!found) begin
         dpb = DPB_CAP;
      end else begin
         wq    = w.pic_width / 16;
         hq    = w.pic_height / 16;
         count = wq * hq;
         if (count == 0) begin
            dpb = DPB_CAP;
         end else begin
            dpb = mbs / count;
            if (dpb > DPB_CAP) begin
               dpb = DPB_CAP;
            end
         end
      end
      reorder = dpb;
      if (restricted) begin
         reorder = (w.reorder_frames_in > dpb) ? dpb : w.reorder_frames_in;
      end else if (w.profile_code == PROFILE_BASELINE ||
                   w.profile_code == PROFILE_SCALABLE_BL) begin
         reorder = 0;
      end else if (w.constraint_three && (w.profile_code inside {PROFILE_CAVLC444,
                   PROFILE_SCALABLE_HI, PROFILE_HIGH, PROFILE_HIGH10,
                   PROFILE_HIGH422, PROFILE_HIGH444})) begin
         reorder = 0;
      end
      r.dpb_frames     = 8'(dpb);
      r.reorder_window = 8'(reorder);
      r.level_found    = found;
      return r;
   endfunction

   function automatic void add_row(input logic [7:0] lvl, input logic [7:0] prof,
                                   input bit cs3, input bit vui, input bit restr,
                                   input logic [7:0] dec, input logic [7:0] reord,
                                   input int unsigned wd, input int unsigned ht,
                                   input bit typed = 1'b0, input int unsigned dpb = 0,
                                   input int unsigned rw = 0, input bit found = 1'b0);
      stim_row_type row;
      row.word.level_code          = lvl;
      row.word.profile_code        = prof;
      row.word.constraint_three    = cs3;
      row.word.vui_present         = vui;
      row.word.restriction_present = restr;
      row.word.dec_frame_buffering = dec;
      row.word.reorder_frames_in   = reord;
      row.word.pic_width           = PIC_W'(wd);
      row.word.pic_height          = PIC_W'(ht);
      row.typed                    = typed;
      row.want.dpb_frames          = 8'(dpb);
      row.want.reorder_window      = 8'(rw);
      row.want.level_found         = found;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [PIC_W-1:0] random_dim();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return PIC_W'($urandom_range(1, 256) * 16 + $urandom_range(0, 15) * $urandom_range(0, 1));
      end else if (pick < 85) begin
         return PIC_W'($urandom_range(0, 63));
      end
      return PIC_W'($urandom_range(0, 32767));
   endfunction

   function automatic req_word_type random_sps_word();
      req_word_type w;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         w.level_code = LEVEL_11;
      end else if (pick < 75) begin
         w.level_code = level_ids[$urandom_range(NUM_LEVELS - 1)];
      end else begin
         w.level_code = 8'($urandom_range(255));
      end
      if ($urandom_range(99) < 65) begin
         w.profile_code = profile_ids[$urandom_range(NUM_PROFILES - 1)];
      end else begin
         w.profile_code = 8'($urandom_range(255));
      end
      w.constraint_three    = 1'($urandom_range(1));
      w.vui_present         = 1'($urandom_range(1));
      w.restriction_present = 1'($urandom_range(1));
      w.dec_frame_buffering = 8'($urandom_range(1) ? $urandom_range(20) : $urandom_range(255));
      w.reorder_frames_in   = 8'($urandom_range(1) ? $urandom_range(20) : $urandom_range(255));
      w.pic_width           = random_dim();
      w.pic_height          = random_dim();
      return w;
   endfunction

   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(typed ? want : derive_dpb_window(w));
   endtask

   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      results_seen++;
      if (expected_results.size() == 0) begin
         error_count++;
         $display("%0t: result word with none expected: dpb %0d reorder %0d found %0d",
                  $time, got.dpb_frames, got.reorder_window, got.level_found);
      end else begin
         want = expected_results.pop_front();
         check_field("dpb_frames", want.dpb_frames, got.dpb_frames);
         check_field("reorder_window", want.reorder_window, got.reorder_window);
         check_field("level_found", want.level_found, got.level_found);
      end
   endtask

   // result side, with one long hold-off so the pipe fills and stalls its input
   initial begin
      int unsigned hold_left;
      bit          held;
      hold_left = 0;
      held      = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            check_result(rsp_bus.data);
         end
         if (!held && results_seen == HOLD_AT_RESULT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !reset && ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("h264_reorder_window_calc verification failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;

      add_row(8'd0, 8'd0, 0, 0, 0, 8'd0, 8'd0, 0, 0, 1, 16, 16, 0);
      add_row(8'd255, 8'd255, 1, 1, 1, 8'd255, 8'd255, 32767, 32767, 1, 255, 255, 0);
      add_row(8'd14, PROFILE_BASELINE, 0, 0, 0, 8'd0, 8'd0, 352, 288, 1, 16, 0, 0);
      // zero macroblock count from either side
      add_row(8'd40, PROFILE_MAIN, 0, 0, 0, 8'd0, 8'd0, 15, 1080, 1, 16, 16, 1);
      add_row(8'd40, PROFILE_HIGH, 0, 0, 0, 8'd0, 8'd0, 1920, 0, 1, 16, 16, 1);
      // restriction with zero buffering floors to one frame
      add_row(8'd30, PROFILE_MAIN, 0, 1, 1, 8'd0, 8'd5, 1920, 1080, 1, 1, 1, 1);
      add_row(8'd30, PROFILE_MAIN, 0, 1, 1, 8'd4, 8'd2, 1920, 1080);
      add_row(8'd30, PROFILE_MAIN, 0, 1, 0, 8'd4, 8'd2, 720, 576);
      add_row(8'd30, PROFILE_MAIN, 0, 0, 1, 8'd4, 8'd2, 720, 576);
      // level 1b mapping and its near misses
      add_row(LEVEL_11, PROFILE_BASELINE, 1, 0, 0, 8'd0, 8'd0, 176, 144);
      add_row(LEVEL_11, PROFILE_MAIN, 1, 0, 0, 8'd0, 8'd0, 176, 144);
      add_row(LEVEL_11, PROFILE_HIGH, 1, 0, 0, 8'd0, 8'd0, 176, 144);
      add_row(LEVEL_11, PROFILE_MAIN, 0, 0, 0, 8'd0, 8'd0, 176, 144);
      add_row(LEVEL_1B, PROFILE_HIGH, 0, 0, 0, 8'd0, 8'd0, 176, 144);
      add_row(8'd51, PROFILE_HIGH, 0, 0, 0, 8'd0, 8'd0, 1920, 1080);
      add_row(8'd30, PROFILE_MAIN, 0, 0, 0, 8'd0, 8'd0, 1920, 1088);
      add_row(8'd62, PROFILE_SCALABLE_BL, 0, 0, 0, 8'd0, 8'd0, 32767, 32767);
      add_row(8'd62, PROFILE_MAIN, 0, 0, 0, 8'd0, 8'd0, 16384, 16384);
      // intra-only profiles with and without constraint_set3
      add_row(8'd41, PROFILE_CAVLC444, 1, 0, 0, 8'd0, 8'd0, 1280, 720);
      add_row(8'd41, PROFILE_SCALABLE_HI, 1, 0, 0, 8'd0, 8'd0, 1280, 720);
      add_row(8'd41, PROFILE_HIGH10, 1, 0, 0, 8'd0, 8'd0, 1280, 720);
      add_row(8'd41, PROFILE_HIGH422, 1, 0, 0, 8'd0, 8'd0, 1280, 720);
      add_row(8'd41, PROFILE_HIGH444, 1, 0, 0, 8'd0, 8'd0, 1280, 720);
      add_row(8'd41, PROFILE_HIGH444, 0, 0, 0, 8'd0, 8'd0, 1280, 720);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = phase_send_idle[0];
      rcv_idle_pct  = phase_rcv_idle[0];
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      end
      pause_until_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = phase_send_idle[p];
         rcv_idle_pct  = phase_rcv_idle[p];
         repeat (RANDOM_PER_PHASE) begin
            send_word(random_sps_word(), 1'b0, '0);
         end
         pause_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("h264_reorder_window_calc verification clean");
      end else begin
         $display("h264_reorder_window_calc verification failed");
      end
      $finish;
   end

endmodule
